FILE: rtl/lbp_pkg.sv
`timescale 1ns / 1ps
// lbp_pkg: command codes, field widths and the result word layout
// for the buffer pool tag engine; no dependencies

package lbp_pkg;

  // widths of the stream fields
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FILE_W  = 8;
  localparam int unsigned BLOCK_W = 24;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CAP_W   = 7;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_READ  = 3'd0;
  localparam cmd_t CMD_WRITE = 3'd1;
  localparam cmd_t CMD_PIN   = 3'd2;
  localparam cmd_t CMD_DROP  = 3'd3;
  localparam cmd_t CMD_FLUSH = 3'd4;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd16;

  // how the rank sweep rewrites surviving entries
  typedef enum logic [1:0] {
    UPD_HIT,
    UPD_INSERT,
    UPD_EVICT,
    UPD_DROP
  } upd_mode_e;

  // one result word
  typedef struct packed {
    logic               hit;
    logic               need_fetch;
    logic [SLOT_W-1:0]  slot;
    logic               ok;
    logic               writeback;
    logic [FILE_W-1:0]  wb_file_id;
    logic [BLOCK_W-1:0] wb_block_number;
    logic [SLOT_W-1:0]  wb_slot;
    logic               last;
  } res_t;

endpackage

FILE: rtl/lru_buffer_pool_with_pinning_top.sv
`timescale 1ns / 1ps
// lru_buffer_pool_with_pinning_top: tag and replacement engine of a fully
// associative page buffer with lru order, pinning and dirty tracking
// depends on lbp_pkg
//
// sequence: read, write, pin and drop_file go from the accepted word through
//   one key/rank scan of the memories, a decision state and, unless all is
//   pinned, one rank rewrite sweep to the result word; an unknown command skips to it
// flush walks the slots in order, one word per dirty slot, waiting on output stalls
// throughput: one command at a time, the next is taken only once the last is done;
//   the two sweeps over the single read port of each memory set its length
// reset: valid, dirty and pinned flags clear at once, capacity returns to 16,
//   key and rank memories are not cleared and need no clearing pass

module lru_buffer_pool_with_pinning_top #(
  parameter int unsigned ENTRIES        = 16,
  parameter int unsigned FILE_ID_BITS   = 8,
  parameter int unsigned BLOCK_NUM_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // capacity register
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,

  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // file_id[7:0], block_number[31:8]
  input  logic [2:0]  s_axis_tuser,   // command[2:0]

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], need_fetch[1], slot[7:2], ok[8], writeback[9], wb_file_id[17:10],
  // wb_block_number[41:18], wb_slot[47:42]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // slot index and rank widths follow the number of entries
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned SW = RW + 1;            // counts up to ENTRIES
  localparam int unsigned KW = FILE_ID_BITS + BLOCK_NUM_BITS;
  localparam int unsigned NG = (ENTRIES + 7) / 8; // popcount groups of eight
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [6:0]    CAP_MAX  = 7'(ENTRIES);

  // state codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_UPD     = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_FL_ADDR = 3'd5;
  localparam logic [2:0] S_FL_DATA = 3'd6;

  logic [2:0] state_q;

  // ---------------------------------------------------------------------
  // command latch and configuration
  // ---------------------------------------------------------------------
  logic                      in_acc;
  lbp_pkg::cmd_t             cmd_q;
  logic [FILE_ID_BITS-1:0]   file_q;
  logic [BLOCK_NUM_BITS-1:0] blk_q;
  logic [6:0]                cap_q;
  logic [6:0]                cap_eff;
  logic                      is_lookup;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_lookup     = (cmd_q == lbp_pkg::CMD_READ) || (cmd_q == lbp_pkg::CMD_WRITE) ||
                         (cmd_q == lbp_pkg::CMD_PIN);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= s_axis_tuser;
      file_q <= FILE_ID_BITS'(s_axis_tdata[7:0]);
      blk_q  <= BLOCK_NUM_BITS'(s_axis_tdata[31:8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lbp_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_q == 7'd0) begin
      cap_eff = 7'd1;
    end else if (cap_q > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_q;
    end
  end

  // ---------------------------------------------------------------------
  // key and rank memories, one read and one write port each
  // ---------------------------------------------------------------------
  logic [KW-1:0] key_mem  [ENTRIES];
  logic [RW-1:0] rank_mem [ENTRIES];
  logic [KW-1:0] key_rd_q;
  logic [RW-1:0] rank_rd_q;

  logic [IW-1:0] sc_idx_q;   // read address, also the flush slot
  logic          sc_run_q;   // sweep still issuing reads
  logic          p_vld_q;    // read data valid for p_idx_q
  logic [IW-1:0] p_idx_q;

  logic          key_we;
  logic [IW-1:0] key_waddr;
  logic          rank_we;
  logic [RW-1:0] rank_new;

  logic [IW-1:0] u_idx_q;
  logic          u_vld_q;

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[sc_idx_q];
    rank_rd_q <= rank_mem[sc_idx_q];
    if (key_we) begin
      key_mem[key_waddr] <= {file_q, blk_q};
    end
    if (rank_we) begin
      rank_mem[u_idx_q] <= rank_new;
    end
  end

  // ---------------------------------------------------------------------
  // flags, one bit per entry
  // ---------------------------------------------------------------------
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [ENTRIES-1:0] pinned_q;

  // ---------------------------------------------------------------------
  // scan: first match, free slot, occupancy, oldest unpinned victim,
  // and for drop_file the slots and ranks that go
  // ---------------------------------------------------------------------
  logic [FILE_ID_BITS-1:0]   kf;
  logic [BLOCK_NUM_BITS-1:0] kb;
  logic                      pv;
  logic                      fm;
  logic                      km;

  logic                      found_q;
  logic [IW-1:0]             fslot_q;
  logic [RW-1:0]             frank_q;
  logic                      vic_q;
  logic [IW-1:0]             vslot_q;
  logic [RW-1:0]             vrank_q;
  logic [FILE_ID_BITS-1:0]   vfile_q;
  logic [BLOCK_NUM_BITS-1:0] vblk_q;
  logic [IW:0]               cnt_q;
  logic                      free_q;
  logic [IW-1:0]             freeslot_q;
  logic [ENTRIES-1:0]        drop_slots_q;
  logic [ENTRIES-1:0]        drop_rmask_q;

  assign kf = key_rd_q[KW-1:BLOCK_NUM_BITS];
  assign kb = key_rd_q[BLOCK_NUM_BITS-1:0];
  assign pv = valid_q[p_idx_q];
  assign fm = pv && (kf == file_q);
  assign km = fm && (kb == blk_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found_q      <= 1'b0;
      vic_q        <= 1'b0;
      free_q       <= 1'b0;
      cnt_q        <= '0;
      drop_slots_q <= '0;
      drop_rmask_q <= '0;
    end else if (state_q == S_SCAN && p_vld_q) begin
      if (km && !found_q) begin
        found_q <= 1'b1;
        fslot_q <= p_idx_q;
        frank_q <= rank_rd_q;
      end
      // strict compare keeps the lowest slot on equal ranks
      if (pv && !pinned_q[p_idx_q] && (!vic_q || rank_rd_q > vrank_q)) begin
        vic_q   <= 1'b1;
        vslot_q <= p_idx_q;
        vrank_q <= rank_rd_q;
        vfile_q <= kf;
        vblk_q  <= kb;
      end
      if (pv) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!free_q) begin
        free_q     <= 1'b1;
        freeslot_q <= p_idx_q;
      end
      if (fm) begin
        drop_slots_q[p_idx_q]   <= 1'b1;
        drop_rmask_q[rank_rd_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // decision after the scan
  // ---------------------------------------------------------------------
  logic dec_ins;
  logic dec_evi;

  assign dec_ins   = !found_q && (7'(cnt_q) < cap_eff) && free_q;
  assign dec_evi   = !found_q && !dec_ins && vic_q;
  assign key_waddr = dec_ins ? freeslot_q : vslot_q;
  assign key_we    = (state_q == S_DECIDE) && is_lookup && (dec_ins || dec_evi);

  lbp_pkg::upd_mode_e mode_q;
  logic [IW-1:0]      tgt_q;
  logic [RW-1:0]      tr_q;
  lbp_pkg::res_t      res_q;

  // ---------------------------------------------------------------------
  // rank rewrite sweep, two stages after the read
  // stage one: ranks below this one that drop_file removes, in groups
  // stage two: sum of groups and the new rank
  // ---------------------------------------------------------------------
  logic [RW-1:0] u_rank_q;
  logic [3:0]    grp_d [NG];
  logic [3:0]    u_grp_q [NG];
  logic [SW-1:0] drop_below;

  always_comb begin
    logic [ENTRIES-1:0] lowm;
    logic [3:0]         c;
    for (int j = 0; j < ENTRIES; j++) begin
      lowm[j] = drop_rmask_q[j] && (RW'(j) < rank_rd_q);
    end
    for (int g = 0; g < NG; g++) begin
      c = 4'd0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < ENTRIES) begin
          c = c + 4'(lowm[g * 8 + k]);
        end
      end
      grp_d[g] = c;
    end
  end

  always_ff @(posedge clk_i) begin
    u_idx_q  <= p_idx_q;
    u_rank_q <= rank_rd_q;
    for (int g = 0; g < NG; g++) begin
      u_grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    logic [SW-1:0] s;
    s = '0;
    for (int g = 0; g < NG; g++) begin
      s = s + SW'(u_grp_q[g]);
    end
    drop_below = s;
  end

  always_comb begin
    rank_new = u_rank_q;
    if (u_idx_q == tgt_q && mode_q != lbp_pkg::UPD_DROP) begin
      rank_new = '0;
    end else begin
      case (mode_q)
        lbp_pkg::UPD_HIT: begin
          if (u_rank_q < tr_q) rank_new = u_rank_q + 1'b1;
        end
        lbp_pkg::UPD_INSERT: begin
          rank_new = u_rank_q + 1'b1;
        end
        lbp_pkg::UPD_EVICT: begin
          // removal then insertion: older than the victim stays put
          if (!(u_rank_q > tr_q)) rank_new = u_rank_q + 1'b1;
        end
        default: begin
          rank_new = u_rank_q - RW'(drop_below);
        end
      endcase
    end
  end

  assign rank_we = u_vld_q && (valid_q[u_idx_q] ||
                   (u_idx_q == tgt_q && mode_q != lbp_pkg::UPD_DROP));

  // ---------------------------------------------------------------------
  // flush: dirty entries above the current slot decide last
  // ---------------------------------------------------------------------
  logic fl_dirty;
  logic fl_more;
  logic fl_any_q;

  assign fl_dirty = valid_q[sc_idx_q] && dirty_q[sc_idx_q];

  always_comb begin
    logic [ENTRIES-1:0] above;
    for (int j = 0; j < ENTRIES; j++) begin
      above[j] = valid_q[j] && dirty_q[j] && (IW'(j) > sc_idx_q);
    end
    fl_more = |above;
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic          ov_q;
  lbp_pkg::res_t out_q;
  logic          out_free;

  assign out_free = !ov_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end else if (state_q == S_FL_DATA && fl_dirty && out_free) begin
      out_q                 <= '0;
      out_q.ok              <= 1'b1;
      out_q.writeback       <= 1'b1;
      out_q.wb_file_id      <= lbp_pkg::FILE_W'(kf);
      out_q.wb_block_number <= lbp_pkg::BLOCK_W'(kb);
      out_q.wb_slot         <= lbp_pkg::SLOT_W'(sc_idx_q);
      out_q.last            <= !fl_more;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {out_q.wb_slot, out_q.wb_block_number, out_q.wb_file_id,
                          out_q.writeback, out_q.ok, out_q.slot,
                          out_q.need_fetch, out_q.hit};

  // result of a lookup or drop, built at the decision; an unknown command keeps the empty word set at accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q      <= '0;
      res_q.last <= 1'b1;
    end else if (state_q == S_DECIDE) begin
      res_q      <= '0;
      res_q.last <= 1'b1;
      if (!is_lookup) begin
        res_q.ok <= 1'b1;
      end else if (found_q) begin
        res_q.hit  <= 1'b1;
        res_q.slot <= lbp_pkg::SLOT_W'(fslot_q);
        res_q.ok   <= 1'b1;
      end else if (dec_ins) begin
        res_q.need_fetch <= 1'b1;
        res_q.slot       <= lbp_pkg::SLOT_W'(freeslot_q);
        res_q.ok         <= 1'b1;
      end else if (dec_evi) begin
        res_q.need_fetch <= 1'b1;
        res_q.slot       <= lbp_pkg::SLOT_W'(vslot_q);
        res_q.ok         <= 1'b1;
        if (dirty_q[vslot_q]) begin
          res_q.writeback       <= 1'b1;
          res_q.wb_file_id      <= lbp_pkg::FILE_W'(vfile_q);
          res_q.wb_block_number <= lbp_pkg::BLOCK_W'(vblk_q);
          res_q.wb_slot         <= lbp_pkg::SLOT_W'(vslot_q);
        end
      end else if (cmd_q == lbp_pkg::CMD_WRITE) begin
        // everything pinned: the write goes straight to the file
        res_q.writeback       <= 1'b1;
        res_q.wb_file_id      <= lbp_pkg::FILE_W'(file_q);
        res_q.wb_block_number <= lbp_pkg::BLOCK_W'(blk_q);
      end
    end else if (state_q == S_FL_DATA && sc_idx_q == LAST_IDX) begin
      res_q      <= '0;
      res_q.ok   <= 1'b1;
      res_q.last <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer, flags and sweep control
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      dirty_q  <= '0;
      pinned_q <= '0;
      sc_idx_q <= '0;
      sc_run_q <= 1'b0;
      p_vld_q  <= 1'b0;
      p_idx_q  <= '0;
      u_vld_q  <= 1'b0;
      ov_q     <= 1'b0;
      fl_any_q <= 1'b0;
      mode_q   <= lbp_pkg::UPD_HIT;
      tgt_q    <= '0;
      tr_q     <= '0;
    end else begin
      if (m_axis_tready) ov_q <= 1'b0;

      // read pipeline of the sweeps
      if (sc_run_q) begin
        if (sc_idx_q == LAST_IDX) begin
          sc_run_q <= 1'b0;
        end else begin
          sc_idx_q <= sc_idx_q + 1'b1;
        end
      end
      p_vld_q <= sc_run_q;
      p_idx_q <= sc_idx_q;
      u_vld_q <= p_vld_q && (state_q == S_UPD);

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sc_idx_q <= '0;
            fl_any_q <= 1'b0;
            if (s_axis_tuser == lbp_pkg::CMD_FLUSH) begin
              state_q <= S_FL_ADDR;
            end else if (s_axis_tuser == lbp_pkg::CMD_READ ||
                         s_axis_tuser == lbp_pkg::CMD_WRITE ||
                         s_axis_tuser == lbp_pkg::CMD_PIN ||
                         s_axis_tuser == lbp_pkg::CMD_DROP) begin
              sc_run_q <= 1'b1;
              state_q  <= S_SCAN;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end

        S_SCAN: begin
          if (p_vld_q && p_idx_q == LAST_IDX) begin
            state_q <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          state_q  <= S_UPD;
          sc_idx_q <= '0;
          sc_run_q <= 1'b1;
          if (!is_lookup) begin
            mode_q   <= lbp_pkg::UPD_DROP;
            valid_q  <= valid_q & ~drop_slots_q;
            dirty_q  <= dirty_q & ~drop_slots_q;
            pinned_q <= pinned_q & ~drop_slots_q;
          end else if (found_q) begin
            mode_q <= lbp_pkg::UPD_HIT;
            tgt_q  <= fslot_q;
            tr_q   <= frank_q;
            if (cmd_q == lbp_pkg::CMD_WRITE) dirty_q[fslot_q] <= 1'b1;
            if (cmd_q == lbp_pkg::CMD_PIN) pinned_q[fslot_q] <= 1'b1;
          end else if (dec_ins || dec_evi) begin
            mode_q              <= dec_ins ? lbp_pkg::UPD_INSERT : lbp_pkg::UPD_EVICT;
            tgt_q               <= key_waddr;
            tr_q                <= vrank_q;
            valid_q[key_waddr]  <= 1'b1;
            dirty_q[key_waddr]  <= (cmd_q == lbp_pkg::CMD_WRITE);
            pinned_q[key_waddr] <= (cmd_q == lbp_pkg::CMD_PIN);
          end else begin
            // all pinned: nothing changes
            state_q  <= S_EMIT;
            sc_run_q <= 1'b0;
          end
        end

        S_UPD: begin
          if (u_vld_q && u_idx_q == LAST_IDX) begin
            state_q <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end

        S_FL_ADDR: begin
          state_q <= S_FL_DATA;
        end

        S_FL_DATA: begin
          if (!fl_dirty || out_free) begin
            if (fl_dirty) begin
              ov_q     <= 1'b1;
              fl_any_q <= 1'b1;
            end
            if (sc_idx_q == LAST_IDX) begin
              valid_q  <= '0;
              dirty_q  <= '0;
              pinned_q <= '0;
              state_q  <= (!fl_any_q && !fl_dirty) ? S_EMIT : S_IDLE;
            end else begin
              sc_idx_q <= sc_idx_q + 1'b1;
              state_q  <= S_FL_ADDR;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while the previous one is in progress");

  // only flush gives more than one word, and every such word is a write-back
  a_mid_word_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> out_q.writeback && out_q.ok)
    else $error("non-final result word that is not a flush write-back");

  // a hit is served from the buffer and never asks for a fetch
  a_hit_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.hit) |-> (out_q.ok && !out_q.need_fetch))
    else $error("hit reported with fetch or without ok");

  // pinned and dirty marks only on resident entries
  a_flags_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pinned_q | dirty_q) & ~valid_q) == '0)
    else $error("pinned or dirty mark on an empty slot");

endmodule

FILE: bench/lbp_checker.sv
`timescale 1ns / 1ps
// lbp_checker: watches the command, result and capacity ports of the buffer pool
// tag engine, keeps its own copy of the slot table and compares every result word
// depends on lbp_pkg

module lbp_checker
  import lbp_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          replies_due_o
);

  localparam int MAX_REPORTS = 10;

  logic [CAP_W-1:0]   cap_reg;
  logic               ent_valid  [ENTRIES];
  logic [FILE_W-1:0]  ent_file   [ENTRIES];
  logic [BLOCK_W-1:0] ent_block  [ENTRIES];
  logic               ent_dirty  [ENTRIES];
  logic               ent_pinned [ENTRIES];
  logic [SLOT_W-1:0]  ent_rank   [ENTRIES];

  res_t pool_replies_due[$];
  res_t seen_reply;
  res_t due_reply;

  function automatic res_t pack_reply(logic hit, logic fetch, logic [SLOT_W-1:0] slot,
                                      logic ok, logic wb, logic [FILE_W-1:0] wf,
                                      logic [BLOCK_W-1:0] wbn, logic [SLOT_W-1:0] ws,
                                      logic last);
    res_t r;
    r.hit             = hit;
    r.need_fetch      = fetch;
    r.slot            = slot;
    r.ok              = ok;
    r.writeback       = wb;
    r.wb_file_id      = wf;
    r.wb_block_number = wbn;
    r.wb_slot         = ws;
    r.last            = last;
    return r;
  endfunction

  function automatic string reply_text(res_t r);
    return $sformatf("hit=%0d fetch=%0d slot=%0d ok=%0d wb=%0d wb_file=%0h wb_block=%0h wb_slot=%0d last=%0d",
                     r.hit, r.need_fetch, r.slot, r.ok, r.writeback, r.wb_file_id,
                     r.wb_block_number, r.wb_slot, r.last);
  endfunction

  // drop a slot and close the gap it leaves in the recency order
  task automatic free_slot(int s);
    logic [SLOT_W-1:0] old_rank;
    old_rank      = ent_rank[s];
    ent_valid[s]  = 1'b0;
    ent_dirty[s]  = 1'b0;
    ent_pinned[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_rank[i] > old_rank) ent_rank[i] = ent_rank[i] - 1'b1;
  endtask

  // new entry becomes most recent, everyone else ages by one
  task automatic place_entry(int s, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b,
                             logic dirty, logic pinned);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i]) ent_rank[i] = ent_rank[i] + 1'b1;
    ent_valid[s]  = 1'b1;
    ent_file[s]   = f;
    ent_block[s]  = b;
    ent_dirty[s]  = dirty;
    ent_pinned[s] = pinned;
    ent_rank[s]   = '0;
  endtask

  task automatic pool_step(cmd_t cmd, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
    int found;
    int count;
    int freeslot;
    int victim;
    int cap;
    int n;
    logic [SLOT_W-1:0] old_rank;
    logic wb;
    res_t r;
    if (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_PIN) begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && ent_valid[i] && ent_file[i] == f && ent_block[i] == b) found = i;
      if (found >= 0) begin
        if (cmd == CMD_WRITE) ent_dirty[found] = 1'b1;
        if (cmd == CMD_PIN) ent_pinned[found] = 1'b1;
        old_rank = ent_rank[found];
        for (int i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && ent_rank[i] < old_rank) ent_rank[i] = ent_rank[i] + 1'b1;
        ent_rank[found] = '0;
        pool_replies_due.push_back(pack_reply(1, 0, SLOT_W'(found), 1, 0, 0, 0, 0, 1));
      end else begin
        cap = int'(cap_reg);
        if (cap < 1) cap = 1;
        if (cap > ENTRIES) cap = ENTRIES;
        count    = 0;
        freeslot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_valid[i]) count++;
          else if (freeslot < 0) freeslot = i;
        end
        if (count < cap && freeslot >= 0) begin
          place_entry(freeslot, f, b, cmd == CMD_WRITE, cmd == CMD_PIN);
          pool_replies_due.push_back(pack_reply(0, 1, SLOT_W'(freeslot), 1, 0, 0, 0, 0, 1));
        end else begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && !ent_pinned[i] &&
                (victim < 0 || ent_rank[i] > ent_rank[victim])) victim = i;
          if (victim < 0) begin
            // everything pinned: bypass, a write goes straight to its file
            if (cmd == CMD_WRITE) pool_replies_due.push_back(pack_reply(0, 0, 0, 0, 1, f, b, 0, 1));
            else pool_replies_due.push_back(pack_reply(0, 0, 0, 0, 0, 0, 0, 0, 1));
          end else begin
            wb = ent_dirty[victim];
            r  = pack_reply(0, 1, SLOT_W'(victim), 1, wb,
                            wb ? ent_file[victim] : '0, wb ? ent_block[victim] : '0,
                            wb ? SLOT_W'(victim) : '0, 1);
            free_slot(victim);
            place_entry(victim, f, b, cmd == CMD_WRITE, cmd == CMD_PIN);
            pool_replies_due.push_back(r);
          end
        end
      end
    end else if (cmd == CMD_DROP) begin
      for (int i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && ent_file[i] == f) free_slot(i);
      pool_replies_due.push_back(pack_reply(0, 0, 0, 1, 0, 0, 0, 0, 1));
    end else if (cmd == CMD_FLUSH) begin
      n = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && ent_dirty[i]) begin
          pool_replies_due.push_back(pack_reply(0, 0, 0, 1, 1, ent_file[i], ent_block[i],
                                                SLOT_W'(i), 0));
          n++;
        end
      if (n == 0) pool_replies_due.push_back(pack_reply(0, 0, 0, 1, 0, 0, 0, 0, 1));
      else pool_replies_due[pool_replies_due.size()-1].last = 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i]  = 1'b0;
        ent_dirty[i]  = 1'b0;
        ent_pinned[i] = 1'b0;
      end
    end else begin
      pool_replies_due.push_back(pack_reply(0, 0, 0, 0, 0, 0, 0, 0, 1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i]  = 1'b0;
        ent_dirty[i]  = 1'b0;
        ent_pinned[i] = 1'b0;
        ent_file[i]   = '0;
        ent_block[i]  = '0;
        ent_rank[i]   = '0;
      end
      pool_replies_due.delete();
      fail_count_o  = 0;
      replies_due_o = 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) begin
        seen_reply.hit             = m_tdata_i[0];
        seen_reply.need_fetch      = m_tdata_i[1];
        seen_reply.slot            = m_tdata_i[7:2];
        seen_reply.ok              = m_tdata_i[8];
        seen_reply.writeback       = m_tdata_i[9];
        seen_reply.wb_file_id      = m_tdata_i[17:10];
        seen_reply.wb_block_number = m_tdata_i[41:18];
        seen_reply.wb_slot         = m_tdata_i[47:42];
        seen_reply.last            = m_tlast_i;
        if (pool_replies_due.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t: result word with none due: %s", $realtime, reply_text(seen_reply));
          fail_count_o++;
        end else begin
          due_reply = pool_replies_due.pop_front();
          if (seen_reply.hit !== due_reply.hit ||
              seen_reply.need_fetch !== due_reply.need_fetch ||
              seen_reply.slot !== due_reply.slot ||
              seen_reply.ok !== due_reply.ok ||
              seen_reply.writeback !== due_reply.writeback ||
              seen_reply.wb_file_id !== due_reply.wb_file_id ||
              seen_reply.wb_block_number !== due_reply.wb_block_number ||
              seen_reply.wb_slot !== due_reply.wb_slot ||
              seen_reply.last !== due_reply.last) begin
            if (fail_count_o < MAX_REPORTS) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", reply_text(due_reply));
              $display("  actual   %s", reply_text(seen_reply));
            end
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        pool_step(cmd_t'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[31:8]);
      replies_due_o = pool_replies_due.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for the buffer pool tag engine; drives commands
// and capacity writes, results are judged by lbp_checker
// depends on lbp_pkg, lbp_checker and lru_buffer_pool_with_pinning_top

module tb;
  import lbp_pkg::*;

  localparam int unsigned ENTRIES = 16;

  // reserved command codes, the block must answer them with an empty word
  localparam cmd_t CMD_RSVD5 = 3'd5;
  localparam cmd_t CMD_RSVD6 = 3'd6;
  localparam cmd_t CMD_RSVD7 = 3'd7;

  // slowest command is one scan plus one rewrite sweep
  localparam int SETTLE_CYCLES   = 2 * ENTRIES + 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 18;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // file_id[7:0], block_number[31:8]
  logic [2:0]  s_axis_tuser;   // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // hit[0], need_fetch[1], slot[7:2], ok[8], writeback[9], wb_file_id[17:10],
  // wb_block_number[41:18], wb_slot[47:42]
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  int   fail_count;
  int   replies_due;
  int   idle_cycles;
  logic no_idle;            // set during stretches where neither side holds back
  logic [FILE_W-1:0] file_pool [3];

  lru_buffer_pool_with_pinning_top #(
    .ENTRIES       (ENTRIES),
    .FILE_ID_BITS  (FILE_W),
    .BLOCK_NUM_BITS(BLOCK_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  lbp_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .replies_due_o(replies_due)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // wait drawn per word by either side
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // present one command word and hold it until the block takes it;
  // returns just after the accepting edge, the caller's next step decides
  // whether valid drops
  task automatic send_word(cmd_t cmd, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, f};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and let the block drain completely before touching capacity
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (replies_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [6:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly lookups, pins build up until a flush or drop clears them
  function automatic cmd_t pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 38) return CMD_READ;
    if (roll < 64) return CMD_WRITE;
    if (roll < 76) return CMD_PIN;
    if (roll < 86) return CMD_DROP;
    if (roll < 93) return CMD_FLUSH;
    if (roll < 95) return CMD_RSVD5;
    if (roll < 97) return CMD_RSVD6;
    return CMD_RSVD7;
  endfunction

  // keys come from a small pool so that hits, evictions and drops all happen
  task automatic random_phase(int items);
    logic [FILE_W-1:0]  f;
    logic [BLOCK_W-1:0] b;
    for (int p = 0; p < 3; p++) file_pool[p] = FILE_W'($urandom);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 11) == 0) no_idle = ($urandom_range(0, 2) == 0);
      f = ($urandom_range(0, 9) == 0) ? FILE_W'($urandom) : file_pool[$urandom_range(0, 2)];
      b = ($urandom_range(0, 7) == 0) ? BLOCK_W'($urandom) : BLOCK_W'($urandom_range(0, 7));
      send_word(pick_command(), f, b);
    end
  endtask

  // result side: one drawn stall per word, then ready until the word is taken
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // watchdog on stretches with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** lru_buffer_pool_with_pinning_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_READ;
    no_idle       = 1'b0;
    idle_cycles   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset capacity: hits and misses on the key extremes, reserved codes,
    // drop without write-back, flush with and without dirty entries
    send_word(CMD_READ,  8'h00, 24'h000000);
    send_word(CMD_WRITE, 8'hFF, 24'hFFFFFF);
    send_word(CMD_READ,  8'h00, 24'h000000);
    send_word(CMD_WRITE, 8'h00, 24'h000000);
    send_word(CMD_PIN,   8'hFF, 24'hFFFFFF);
    send_word(CMD_PIN,   8'h5A, 24'hA5A5A5);
    send_word(CMD_RSVD5, 8'hFF, 24'hFFFFFF);
    send_word(CMD_RSVD6, 8'h00, 24'h000000);
    send_word(CMD_RSVD7, 8'h33, 24'h123456);
    send_word(CMD_DROP,  8'h00, 24'hFFFFFF);
    send_word(CMD_FLUSH, 8'h00, 24'h000000);
    send_word(CMD_FLUSH, 8'hFF, 24'hFFFFFF);

    // two slots: dirty eviction, then everything pinned so lookups bypass
    set_capacity(7'd2);
    send_word(CMD_WRITE, 8'h03, 24'd10);
    send_word(CMD_READ,  8'h03, 24'd11);
    send_word(CMD_READ,  8'h03, 24'd12);
    send_word(CMD_PIN,   8'h03, 24'd11);
    send_word(CMD_PIN,   8'h03, 24'd12);
    send_word(CMD_READ,  8'h09, 24'd9);
    send_word(CMD_WRITE, 8'h09, 24'd9);
    send_word(CMD_PIN,   8'h09, 24'd9);
    send_word(CMD_DROP,  8'h03, 24'd0);
    send_word(CMD_FLUSH, 8'h00, 24'd0);

    // zero capacity behaves as a single slot
    set_capacity(7'd0);
    send_word(CMD_READ,  8'h07, 24'd1);
    send_word(CMD_WRITE, 8'h07, 24'd2);
    send_word(CMD_READ,  8'h07, 24'd1);

    // random phases; going from full size to four slots without a flush
    // leaves the store above capacity so misses must evict in place
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_capacity(7'd16);
        1: set_capacity(7'd4);
        2: set_capacity(7'd127);
        3: set_capacity(7'd64);
        4: set_capacity(7'd1);
        5: set_capacity(7'($urandom_range(1, 64)));
        6: set_capacity(7'd0);
        default: set_capacity(7'd8);
      endcase
      random_phase(ITEMS_PER_PHASE);
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0 && replies_due == 0) begin
      $display("** lru_buffer_pool_with_pinning_top: PASSED **");
    end else begin
      $display("** lru_buffer_pool_with_pinning_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lbp_pkg.sv
rtl/lru_buffer_pool_with_pinning_top.sv
bench/lbp_checker.sv
bench/tb.sv
